### hw/rtl/packet_anti_replay_admission_macros.svh
`ifndef PACKET_ANTI_REPLAY_ADMISSION_MACROS_SVH
`define PACKET_ANTI_REPLAY_ADMISSION_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define PAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/par_pkg.sv
`default_nettype none

package par_pkg;

    localparam int unsigned INDEX_W       = 32;
    localparam int unsigned COUNTER_W     = 64;
    localparam int unsigned LENGTH_W      = 16;
    localparam int unsigned STATUS_W      = 3;
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam int unsigned WINDOW_BITS_DEFAULT = 64;
    localparam logic [LENGTH_W-1:0] MIN_LENGTH_RESET = 16'd28;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SESSION_ENABLED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_INDEX     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH      = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT   = 3'd0,
        ST_DISABLED = 3'd1,
        ST_SHORT    = 3'd2,
        ST_INDEX    = 3'd3,
        ST_REPLAY   = 3'd4,
        ST_TAG      = 3'd5
    } status_t;

    typedef struct packed {
        logic                  session_enabled;
        logic [INDEX_W-1:0]    local_index;
        logic [LENGTH_W-1:0]   min_length;
    } cfg_t;

    // Control between the admission stage and the window
    typedef struct packed {
        logic clear;
        logic mark;
    } window_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/packet_anti_replay_admission.sv
`default_nettype none

`include "packet_anti_replay_admission_macros.svh"

// Anti-replay admission for sealed packets. One item per cycle is taken while
// in_stall is low, and one result per item is given, in order; out_valid rises
// once an item has passed the input register and then the result register,
// and the result transfer takes place when the output is not stalled. The
// check and the window update for an item both complete
// in the single cycle in which it moves from the input register to the result
// register, so the next item is already checked against the updated window.
// Status priority: session not enabled, too short, index mismatch, replay or
// stale counter (more than WINDOW_BITS-1 behind the highest, or already seen),
// failed tag. Writing 1 to session_enabled restarts the window; write the
// configuration only while no item is in flight.
module packet_anti_replay_admission #(
    parameter int unsigned WINDOW_BITS = par_pkg::WINDOW_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [par_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [par_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [par_pkg::INDEX_W-1:0]       packet_index,
    input  wire logic [par_pkg::COUNTER_W-1:0]     packet_counter,
    input  wire logic [par_pkg::LENGTH_W-1:0]      packet_length,
    input  wire logic                              tag_ok,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [par_pkg::STATUS_W-1:0]           status,
    output logic [par_pkg::LENGTH_W-1:0]           payload_length
);

    par_pkg::cfg_t          cfg;
    par_pkg::window_ctrl_t  window_ctrl;
    logic                   window_clear;
    logic                   fresh;

    // input register
    logic                              in_full_reg;
    logic                              in_full_next;
    logic [par_pkg::INDEX_W-1:0]       index_reg;
    logic [par_pkg::COUNTER_W-1:0]     counter_reg;
    logic [par_pkg::LENGTH_W-1:0]      length_reg;
    logic                              tag_ok_reg;

    // result register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    par_pkg::status_t                  status_reg;
    par_pkg::status_t                  status_next;
    logic [par_pkg::LENGTH_W-1:0]      payload_length_reg;
    logic [par_pkg::LENGTH_W-1:0]      payload_length_next;

    logic in_transfer;
    logic advance;

    par_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .window_clear (window_clear)
    );

    par_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (window_ctrl),
        .counter (counter_reg),
        .fresh   (fresh)
    );

    // move the held item on whenever the result register is free or draining
    assign advance     = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = in_full_reg && out_valid_reg && out_stall;
    assign in_transfer = in_valid && !in_stall;

    assign in_full_next   = in_transfer || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_comb
    begin
        payload_length_next = '0;
        if (!cfg.session_enabled)
        begin
            status_next = par_pkg::ST_DISABLED;
        end
        else if (length_reg < cfg.min_length)
        begin
            status_next = par_pkg::ST_SHORT;
        end
        else if (index_reg != cfg.local_index)
        begin
            status_next = par_pkg::ST_INDEX;
        end
        else if (!fresh)
        begin
            status_next = par_pkg::ST_REPLAY;
        end
        else if (!tag_ok_reg)
        begin
            status_next = par_pkg::ST_TAG;
        end
        else
        begin
            status_next         = par_pkg::ST_ACCEPT;
            payload_length_next = length_reg - cfg.min_length;
        end
    end

    assign window_ctrl.clear = window_clear;
    assign window_ctrl.mark  = advance && (status_next == par_pkg::ST_ACCEPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            index_reg   <= packet_index;
            counter_reg <= packet_counter;
            length_reg  <= packet_length;
            tag_ok_reg  <= tag_ok;
        end
        if (advance)
        begin
            status_reg         <= status_next;
            payload_length_reg <= payload_length_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign payload_length = payload_length_reg;

    `PAR_ASSERT_NOW(a_reject_no_payload, (out_valid && (status != par_pkg::ST_ACCEPT)), (payload_length == '0), "rejected transfer carries a payload length")
    `PAR_ASSERT_NOW(a_mark_needs_session, window_ctrl.mark, (cfg.session_enabled && !window_ctrl.clear), "window marked without an enabled session")
    `PAR_ASSERT_NEXT(a_advance_gives_result, advance, out_valid, "item left the input register without a result")

endmodule

`default_nettype wire

### hw/rtl/par_cfg.sv
`default_nettype none

module par_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [par_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [par_pkg::CFG_DATA_W-1:0]      cfg_data,
    output par_pkg::cfg_t                            cfg,
    output logic                                     window_clear
);

    logic                            session_enabled_reg;
    logic                            session_enabled_next;
    logic [par_pkg::INDEX_W-1:0]     local_index_reg;
    logic [par_pkg::INDEX_W-1:0]     local_index_next;
    logic [par_pkg::LENGTH_W-1:0]    min_length_reg;
    logic [par_pkg::LENGTH_W-1:0]    min_length_next;

    always_comb
    begin
        session_enabled_next = session_enabled_reg;
        local_index_next     = local_index_reg;
        min_length_next      = min_length_reg;
        window_clear         = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                par_pkg::CFG_SESSION_ENABLED:
                begin
                    session_enabled_next = cfg_data[0];
                    // a fresh session starts a fresh window
                    window_clear         = cfg_data[0];
                end
                par_pkg::CFG_LOCAL_INDEX:
                begin
                    local_index_next = cfg_data[par_pkg::INDEX_W-1:0];
                end
                par_pkg::CFG_MIN_LENGTH:
                begin
                    min_length_next = cfg_data[par_pkg::LENGTH_W-1:0];
                end
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_enabled_reg <= 1'b0;
            local_index_reg     <= '0;
            min_length_reg      <= par_pkg::MIN_LENGTH_RESET;
        end
        else
        begin
            session_enabled_reg <= session_enabled_next;
            local_index_reg     <= local_index_next;
            min_length_reg      <= min_length_next;
        end
    end

    assign cfg.session_enabled = session_enabled_reg;
    assign cfg.local_index     = local_index_reg;
    assign cfg.min_length      = min_length_reg;

endmodule

`default_nettype wire

### hw/rtl/par_window.sv
`default_nettype none

module par_window #(
    parameter int unsigned WINDOW_BITS = par_pkg::WINDOW_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire par_pkg::window_ctrl_t             ctrl,
    input  wire logic [par_pkg::COUNTER_W-1:0]     counter,
    output logic                                   fresh
);

    localparam int unsigned IW = $clog2(WINDOW_BITS);
    localparam logic [par_pkg::COUNTER_W-1:0] WINDOW_SPAN =
        par_pkg::COUNTER_W'(WINDOW_BITS);

    logic                              started_reg;
    logic                              started_next;
    logic [par_pkg::COUNTER_W-1:0]     highest_reg;
    logic [par_pkg::COUNTER_W-1:0]     highest_next;
    logic [WINDOW_BITS-1:0]            mask_reg;
    logic [WINDOW_BITS-1:0]            mask_next;

    logic                              newer;
    logic [par_pkg::COUNTER_W-1:0]     back_dist;
    logic [par_pkg::COUNTER_W-1:0]     fwd_dist;
    logic                              back_in_reach;
    logic                              fwd_in_reach;

    assign newer         = counter > highest_reg;
    assign back_dist     = highest_reg - counter;
    assign fwd_dist      = counter - highest_reg;
    assign back_in_reach = back_dist < WINDOW_SPAN;
    assign fwd_in_reach  = fwd_dist < WINDOW_SPAN;

    assign fresh = !started_reg || newer ||
                   (back_in_reach && !mask_reg[back_dist[IW-1:0]]);

    always_comb
    begin
        started_next = started_reg;
        highest_next = highest_reg;
        mask_next    = mask_reg;
        if (ctrl.clear)
        begin
            started_next = 1'b0;
            highest_next = '0;
            mask_next    = '0;
        end
        else if (ctrl.mark)
        begin
            if (!started_reg)
            begin
                started_next = 1'b1;
                highest_next = counter;
                mask_next    = WINDOW_BITS'(1);
            end
            else if (newer)
            begin
                // slide the window up to the new counter
                highest_next = counter;
                if (fwd_in_reach)
                begin
                    mask_next = (mask_reg << fwd_dist[IW-1:0]) | WINDOW_BITS'(1);
                end
                else
                begin
                    mask_next = WINDOW_BITS'(1);
                end
            end
            else if (back_in_reach)
            begin
                mask_next[back_dist[IW-1:0]] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            highest_reg <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            started_reg <= started_next;
            highest_reg <= highest_next;
            mask_reg    <= mask_next;
        end
    end

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
    import par_pkg::*;

    localparam int WIN = WINDOW_BITS_DEFAULT;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int CHUNKS = 5;
    localparam int CHUNK_ITEMS = 100;

    typedef struct {
        status_t             st;
        logic [LENGTH_W-1:0] pay;
    } verdict_t;

    typedef enum {
        ROW_REG,
        ROW_PACKET
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [INDEX_W-1:0]     idx;
        logic [COUNTER_W-1:0]   ctr;
        logic [LENGTH_W-1:0]    len;
        logic                   tag;
        bit                     typed;
        verdict_t               want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [INDEX_W-1:0]     packet_index = '0;
    logic [COUNTER_W-1:0]   packet_counter = '0;
    logic [LENGTH_W-1:0]    packet_length = '0;
    logic                   tag_ok = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [LENGTH_W-1:0]    payload_length;

    // Predictor copy of the registers and the replay window
    logic                   sess_on;
    logic [INDEX_W-1:0]     rx_index;
    logic [LENGTH_W-1:0]    min_len;
    logic                   win_open;
    logic [COUNTER_W-1:0]   win_top;
    logic [WIN-1:0]         win_seen;

    verdict_t    pending_verdicts[$];
    plan_row_t   plan[$];
    int          send_idle_pct = 0;
    int          rcv_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          packets_sent = 0;
    int          reg_writes = 0;
    int          tally[8];
    int unsigned cycles = 0;

    packet_anti_replay_admission i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .packet_index   (packet_index),
        .packet_counter (packet_counter),
        .packet_length  (packet_length),
        .tag_ok         (tag_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .payload_length (payload_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_window();
        win_open = 1'b0;
        win_top  = '0;
        win_seen = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SESSION_ENABLED:
            begin
                sess_on = data[0];
                if (sess_on)
                    clear_window();
            end
            CFG_LOCAL_INDEX: rx_index = data[INDEX_W-1:0];
            CFG_MIN_LENGTH:  min_len = data[LENGTH_W-1:0];
            default: ;
        endcase
    endfunction

    // Work out the verdict for one packet and advance the window on admission
    function automatic verdict_t admit_packet(logic [INDEX_W-1:0] idx, logic [COUNTER_W-1:0] ctr,
                                              logic [LENGTH_W-1:0] len, logic tag);
        verdict_t             v;
        logic [COUNTER_W-1:0] gap;
        logic                 fresh;
        v.st  = ST_ACCEPT;
        v.pay = '0;
        fresh = 1'b1;
        if (win_open && ctr <= win_top)
        begin
            gap = win_top - ctr;
            if (gap >= WIN)
                fresh = 1'b0;
            else
                fresh = !win_seen[gap[$clog2(WIN)-1:0]];
        end
        if (!sess_on)
            v.st = ST_DISABLED;
        else if (len < min_len)
            v.st = ST_SHORT;
        else if (idx != rx_index)
            v.st = ST_INDEX;
        else if (!fresh)
            v.st = ST_REPLAY;
        else if (!tag)
            v.st = ST_TAG;
        else
        begin
            v.pay = len - min_len;
            if (!win_open)
            begin
                win_open = 1'b1;
                win_top  = ctr;
                win_seen = WIN'(1);
            end
            else if (ctr > win_top)
            begin
                gap = ctr - win_top;
                win_seen = (gap >= WIN) ? WIN'(1) : ((win_seen << gap) | WIN'(1));
                win_top  = ctr;
            end
            else
            begin
                gap = win_top - ctr;
                win_seen[gap[$clog2(WIN)-1:0]] = 1'b1;
            end
        end
        return v;
    endfunction

    task automatic report(string field, logic [LENGTH_W-1:0] got, logic [LENGTH_W-1:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch at cycle %0d: %s got %0h, expected %0h", cycles, field, got, want);
    endtask

    // Drop valid and let everything in flight drain before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        reg_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_packet(logic [INDEX_W-1:0] idx, logic [COUNTER_W-1:0] ctr,
                               logic [LENGTH_W-1:0] len, logic tag, bit typed, verdict_t want);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        packet_index   <= idx;
        packet_counter <= ctr;
        packet_length  <= len;
        tag_ok         <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v = admit_packet(idx, ctr, len, tag);
        pending_verdicts.push_back(typed ? want : v);
        packets_sent++;
    endtask

    function automatic void plan_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        plan.push_back(r);
    endfunction

    function automatic void plan_pkt(logic [INDEX_W-1:0] idx, logic [COUNTER_W-1:0] ctr,
                                     logic [LENGTH_W-1:0] len, logic tag,
                                     bit typed, status_t st, logic [LENGTH_W-1:0] pay);
        plan_row_t r;
        r.kind     = ROW_PACKET;
        r.idx      = idx;
        r.ctr      = ctr;
        r.len      = len;
        r.tag      = tag;
        r.typed    = typed;
        r.want.st  = st;
        r.want.pay = pay;
        plan.push_back(r);
    endfunction

    // Mostly well-formed packets around the current window, the rest noise
    function automatic void pick_packet(output logic [INDEX_W-1:0] idx,
                                        output logic [COUNTER_W-1:0] ctr,
                                        output logic [LENGTH_W-1:0] len, output logic tag);
        int roll;
        int headroom;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            idx = rx_index;
            tag = ($urandom_range(19) != 0);
            headroom = 65535 - int'(min_len);
            if (headroom == 0)
                len = min_len;
            else if ($urandom_range(9) == 0)
                len = LENGTH_W'($urandom_range(65535, int'(min_len)));
            else
                len = min_len + LENGTH_W'($urandom_range(1500) % (headroom + 1));
            roll = $urandom_range(99);
            if (!win_open)
                ctr = {$urandom, $urandom};
            else if (roll < 50)
                ctr = win_top + COUNTER_W'($urandom_range(4, 1));
            else if (roll < 80)
                ctr = win_top - COUNTER_W'($urandom_range(WIN - 1));
            else if (roll < 90)
                ctr = win_top + COUNTER_W'($urandom_range(150, 5));
            else
                ctr = win_top - COUNTER_W'($urandom_range(200, WIN));
        end
        else
        begin
            idx = ($urandom_range(1) != 0) ? rx_index ^ (32'd1 << $urandom_range(31)) : $urandom;
            ctr = {$urandom, $urandom};
            len = LENGTH_W'($urandom_range(65535));
            tag = 1'($urandom_range(1));
        end
    endfunction

    // Receiver: random stall, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && !out_stall)
        begin
            tally[status]++;
            if (pending_verdicts.size() == 0)
                report("unexpected result, status", LENGTH_W'(status), '0);
            else
            begin
                v = pending_verdicts.pop_front();
                if (status !== v.st)
                    report("status", LENGTH_W'(status), LENGTH_W'(v.st));
                if (payload_length !== v.pay)
                    report("payload_length", payload_length, v.pay);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_verdicts.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [INDEX_W-1:0]   idx;
        logic [COUNTER_W-1:0] ctr;
        logic [LENGTH_W-1:0]  len;
        logic                 tag;
        verdict_t             none;
        int                   roll;
        int                   min_pick;

        none.st  = ST_ACCEPT;
        none.pay = '0;
        sess_on  = 1'b0;
        rx_index = '0;
        min_len  = MIN_LENGTH_RESET;
        clear_window();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part; min_length keeps its reset value until written
        plan_pkt('0, '0, '0, 1'b0, 1, ST_DISABLED, '0);
        plan_pkt('1, '1, '1, 1'b1, 1, ST_DISABLED, '0);
        plan_reg(CFG_SESSION_ENABLED, 32'd1);
        plan_reg(CFG_LOCAL_INDEX, 32'hFFFF_FFFF);
        plan_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        plan_pkt('1, 64'd100, 16'd27, 1'b1, 1, ST_SHORT, '0);
        plan_pkt('0, 64'd100, 16'd28, 1'b1, 1, ST_INDEX, '0);
        plan_pkt('1, 64'd100, 16'd28, 1'b0, 1, ST_TAG, '0);
        plan_pkt('1, 64'd100, 16'd28, 1'b1, 1, ST_ACCEPT, '0);
        plan_pkt('1, 64'd100, 16'd28, 1'b1, 1, ST_REPLAY, '0);
        plan_pkt('1, 64'd36, 16'd40, 1'b1, 1, ST_REPLAY, '0);
        plan_pkt('1, 64'd37, 16'hFFFF, 1'b1, 0, ST_ACCEPT, '0);
        plan_pkt('1, 64'd37, 16'd28, 1'b1, 1, ST_REPLAY, '0);
        plan_pkt('1, 64'd101, 16'd1500, 1'b1, 0, ST_ACCEPT, '0);
        plan_pkt('1, 64'd300, 16'd60, 1'b1, 0, ST_ACCEPT, '0);
        plan_pkt('1, 64'd101, 16'd60, 1'b1, 1, ST_REPLAY, '0);
        plan_pkt('1, 64'd299, 16'd60, 1'b1, 0, ST_ACCEPT, '0);
        plan_pkt('1, '1, 16'd60, 1'b1, 0, ST_ACCEPT, '0);
        plan_pkt('1, 64'hFFFF_FFFF_FFFF_FFC0, 16'd60, 1'b1, 0, ST_ACCEPT, '0);
        plan_pkt('1, 64'hFFFF_FFFF_FFFF_FFBF, 16'd60, 1'b1, 1, ST_REPLAY, '0);
        plan_reg(CFG_MIN_LENGTH, 32'h0000_FFFF);
        plan_reg(CFG_LOCAL_INDEX, 32'd0);
        plan_pkt('0, 64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFE, 1'b1, 1, ST_SHORT, '0);
        plan_pkt('0, 64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFF, 1'b1, 0, ST_ACCEPT, '0);
        plan_reg(CFG_SESSION_ENABLED, 32'd0);
        plan_pkt('0, 64'd5, 16'hFFFF, 1'b1, 1, ST_DISABLED, '0);
        // Re-enabling must start a fresh window
        plan_reg(CFG_SESSION_ENABLED, 32'd1);
        plan_reg(CFG_MIN_LENGTH, 32'd0);
        plan_pkt('0, '0, '0, 1'b1, 1, ST_ACCEPT, '0);
        plan_pkt('0, '0, '0, 1'b1, 1, ST_REPLAY, '0);
        plan_pkt('0, 64'd1, 16'hFFFF, 1'b1, 0, ST_ACCEPT, '0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            else
                send_packet(plan[i].idx, plan[i].ctr, plan[i].len, plan[i].tag,
                            plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 32; rcv_stall_pct = 73; end
                1:       begin send_idle_pct = 73; rcv_stall_pct = 32; end
                default: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            endcase
            for (int chunk = 0; chunk < CHUNKS; chunk++)
            begin
                roll = $urandom_range(5);
                if (chunk == 0 || roll < 2)
                    write_reg(CFG_LOCAL_INDEX, $urandom);
                case ($urandom_range(7))
                    0:       min_pick = 0;
                    1:       min_pick = 65535;
                    2:       min_pick = $urandom_range(65535);
                    default: min_pick = $urandom_range(60, 20);
                endcase
                write_reg(CFG_MIN_LENGTH, CFG_DATA_W'(min_pick));
                if (roll == 0 && chunk != 0)
                    write_reg(CFG_SESSION_ENABLED, 32'd0);
                else if (chunk == 0 || roll < 3 || !sess_on)
                    write_reg(CFG_SESSION_ENABLED, 32'd1);
                // Hold the output off long enough to back up the input
                if (ph == 2 && chunk == 1)
                    hold_requests++;
                repeat (CHUNK_ITEMS)
                begin
                    pick_packet(idx, ctr, len, tag);
                    send_packet(idx, ctr, len, tag, 0, none);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d packets and %0d register writes over three stall profiles",
                 packets_sent, reg_writes);
        $display("results: %0d admitted, %0d disabled, %0d short, %0d index, %0d replay, %0d tag",
                 tally[ST_ACCEPT], tally[ST_DISABLED], tally[ST_SHORT], tally[ST_INDEX],
                 tally[ST_REPLAY], tally[ST_TAG]);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/par_pkg.sv
hw/rtl/par_cfg.sv
hw/rtl/par_window.sv
hw/rtl/packet_anti_replay_admission.sv
verif/tb.sv
